/* hw/rtl/stft_pkg.sv */
// Shared types, constants and elaboration-time table builders for the STFT block.
// Used by stft_ram and stft_analysis_frames; depends on nothing else.
`timescale 1ns / 1ps

package stft_pkg;

    localparam int FFT_LEN_DEF    = 64;
    localparam int MAX_N          = 64;
    localparam int HOP_W          = 7;
    localparam int HOP_RESET      = 32;
    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 16;
    localparam int DATA_W         = 32;
    localparam int BIN_W          = 6;
    localparam int TDATA_W        = 72;
    localparam int PADDR_W        = 4;

    localparam logic [PADDR_W-1:0] ADDR_HOP  = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_KIND = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_ROOT = 4'h8;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint HAMM_A_Q30  = 64'sd579820585;
    localparam longint HAMM_B_Q30  = 64'sd493921239;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_MUL,
        ST_LOAD_WR,
        ST_BF_RDQ,
        ST_BF_RDP,
        ST_BF_M0,
        ST_BF_M1,
        ST_BF_M2,
        ST_BF_M3,
        ST_BF_VI,
        ST_BF_WRP,
        ST_BF_WRQ,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_OUT_WAIT
    } stft_state_t;

    // Restoring long division, only ever evaluated while tables are built.
    function automatic logic [63:0] udiv(logic [63:0] a, logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b})
            begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bv;
        v  = v_in;
        r  = '0;
        bv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (bv > v)
                bv = bv >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bv != 0)
            begin
                if (v >= r + bv)
                begin
                    v = v - (r + bv);
                    r = (r >> 1) + bv;
                end
                else
                    r = r >> 1;
                bv = bv >> 2;
            end
        end
        return r;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Q30 cosine and sine of num/den turns; returns {cos, sin}.
    function automatic logic [127:0] trig_q30(longint num, longint den);
        logic [63:0] ph;
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] tc;
        logic [63:0] ts;
        longint      c;
        longint      s;
        longint      co;
        longint      so;
        ph   = udiv((num & 64'hFF) << 32, den) & 64'hFFFF_FFFF;
        quad = ph[31:30];
        r    = {34'd0, ph[29:0]};
        a    = (r * HALF_PI_Q30 + (64'd1 << 29)) >> 30;
        tc   = Q30_ONE;
        ts   = a;
        c    = Q30_ONE;
        s    = a;
        for (int n = 1; n <= 7; n++)
        begin
            tc = udiv((((tc * a) >> 30) * a) >> 30, 64'((2 * n - 1) * (2 * n)));
            ts = udiv((((ts * a) >> 30) * a) >> 30, 64'((2 * n) * (2 * n + 1)));
            if (n % 2 == 1)
            begin
                c = c - tc;
                s = s - ts;
            end
            else
            begin
                c = c + tc;
                s = s + ts;
            end
        end
        case (quad)
            2'd0:    begin co = c;  so = s;  end
            2'd1:    begin co = -s; so = c;  end
            2'd2:    begin co = -c; so = -s; end
            default: begin co = s;  so = -c; end
        endcase
        return {co, so};
    endfunction

    function automatic longint sat_rng(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Four window tables of MAX_N Q1.15 entries, selected by {kind, root}.
    function automatic logic [4*MAX_N*COEF_W-1:0] build_win(int fs);
        logic [4*MAX_N*COEF_W-1:0] tab;
        logic [127:0]              cs;
        longint                    c;
        longint                    w;
        longint                    v;
        tab = '0;
        for (int i = 0; i < fs; i++)
        begin
            cs = trig_q30(i, fs - 1);
            c  = cs[127:64];
            for (int kind = 0; kind < 2; kind++)
            begin
                if (kind == 0)
                    w = (Q30_ONE - c) >>> 1;
                else
                    w = HAMM_A_Q30 - rnd_shift(HAMM_B_Q30 * c, 30);
                w = sat_rng(w, 0, Q30_ONE);
                for (int root = 0; root < 2; root++)
                begin
                    v = (root == 1) ? longint'(isqrt(64'(w) << 30)) : w;
                    tab[((kind * 2 + root) * MAX_N + i) * COEF_W +: COEF_W] =
                        COEF_W'(sat_rng(rnd_shift(v, 15), 0, 32767));
                end
            end
        end
        return tab;
    endfunction

    // Cosine twiddles in the lower half, sine twiddles in the upper half.
    function automatic logic [MAX_N*COEF_W-1:0] build_tw(int n);
        logic [MAX_N*COEF_W-1:0] tab;
        logic [127:0]            cs;
        tab = '0;
        for (int i = 0; i < n / 2; i++)
        begin
            cs = trig_q30(i, n);
            tab[i * COEF_W +: COEF_W] =
                COEF_W'(sat_rng(rnd_shift(cs[127:64], 15), -32768, 32767));
            tab[(MAX_N / 2 + i) * COEF_W +: COEF_W] =
                COEF_W'(sat_rng(rnd_shift(cs[63:0], 15), -32768, 32767));
        end
        return tab;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(logic signed [35:0] v);
        if (v > 36'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -36'sh0_8000_0000)
            return 32'sh8000_0000;
        return v[DATA_W-1:0];
    endfunction

endpackage

/* hw/rtl/stft_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on stft_pkg only for the default WIDTH and DEPTH.
`timescale 1ns / 1ps

module stft_ram
    import stft_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = FFT_LEN_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/stft_analysis_frames.sv */
// Top level of the streaming STFT analysis block: sample ring, windowing,
// radix-2 FFT on one shared multiplier, and bin output. Uses stft_pkg and stft_ram.
`timescale 1ns / 1ps

// Usage
// Samples enter on the s_ channel, one signed 16-bit PCM sample per transaction.
// The first FFT_LEN samples fill the ring; the last of them starts a frame, and
// after that every sample that ends a hop starts another. A sample that starts no
// frame leaves the block idle. A frame runs three phases on one multiplier under the
// sequencer: windowing (a read, a product and a write per sample, FFT_LEN samples,
// written in bit-reversed order), the FFT (per butterfly two reads, four products,
// the imaginary sum and two writes, in an order set by the one read and one write
// port of the work memory and the four products per butterfly; FFT_LEN/2
// butterflies per stage, log2 stages), and output of bins 0..FFT_LEN/2 (a read,
// a capture into the output register, then a wait for the receiver to take it).
// s_tready is low for the whole frame. Bins leave on the m_ channel, one per
// transaction, with m_tlast on the highest bin. If the receiver holds m_tready low,
// the current bin is held in the output register and the sequencer waits.
// Reset clears the ring pointer, fill and hop counters and the registers
// (hop length 32, Hann, no square root); the memories need no clearing, since a
// frame reads only ring entries already written. Configuration goes through the
// APB port, registers at byte addresses 0, 4 and 8; write them only while idle (unenforced).
module stft_analysis_frames
    import stft_pkg::*;
#(
    parameter int FFT_LEN = FFT_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Sample input; s_tdata: pcm_sample[15:0].
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,
    // Bin output; m_tdata: bin_index[5:0], bin_real[37:6], bin_imag[69:38], zero[71:70].
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,
    output logic                 m_tlast,
    // Configuration.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int LOG_N   = $clog2(FFT_LEN);
    localparam int HALF_N  = FFT_LEN / 2;
    localparam int STAGE_W = (LOG_N > 1) ? $clog2(LOG_N) : 1;
    localparam int TW_W    = LOG_N - 1;

    localparam logic [4*MAX_N*COEF_W-1:0] WIN_TAB = build_win(FFT_LEN);
    localparam logic [MAX_N*COEF_W-1:0]   TW_TAB  = build_tw(FFT_LEN);

    // Control state.
    stft_state_t           state_reg, state_next;
    logic [LOG_N-1:0]      cnt_reg, cnt_next;
    logic [STAGE_W-1:0]    stage_reg, stage_next;
    logic [LOG_N-1:0]      wpos_reg, wpos_next;
    logic [LOG_N:0]        fill_reg, fill_next;
    logic [HOP_W-1:0]      hop_cd_reg, hop_cd_next;
    logic [HOP_W-1:0]      hop_reg;
    logic                  kind_reg;
    logic                  root_reg;
    logic                  m_valid_reg, m_valid_next;

    // Datapath registers.
    logic [2*DATA_W-1:0]   b_reg;
    logic [2*DATA_W-1:0]   u_reg;
    logic signed [48:0]    prod_reg;
    logic signed [49:0]    acc_reg;
    logic signed [34:0]    vr_reg;
    logic signed [34:0]    vi_reg;
    logic [TDATA_W-1:0]    m_data_reg;
    logic                  m_last_reg;

    // Memory ports.
    logic                  ring_wr_en;
    logic                  ring_rd_en;
    logic [SAMPLE_W-1:0]   ring_rd_data;
    logic                  work_wr_en;
    logic [LOG_N-1:0]      work_wr_addr;
    logic [2*DATA_W-1:0]   work_wr_data;
    logic                  work_rd_en;
    logic [LOG_N-1:0]      work_rd_addr;
    logic [2*DATA_W-1:0]   work_rd_data;

    // Butterfly addressing.
    logic [LOG_N-1:0]      j_part;
    logic [LOG_N-1:0]      p_addr;
    logic [LOG_N-1:0]      q_addr;
    logic [LOG_N-1:0]      half_step;
    logic [LOG_N-1:0]      ti_full;
    logic [TW_W-1:0]       tw_idx;
    logic [LOG_N-1:0]      rev_cnt;
    logic signed [COEF_W-1:0] wc;
    logic signed [COEF_W-1:0] ws;
    logic [COEF_W-1:0]     win_coef;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [16:0]       mul_b;
    logic signed [DATA_W-1:0] br, bi, ur, ui;
    logic signed [49:0]       vr_sum;
    logic signed [49:0]       vi_sum;
    logic signed [48:0]       win_rnd;

    logic accept;
    logic cfg_wr;
    logic emit;

    assign accept = s_tvalid && s_tready;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign pready   = 1'b1;

    assign br = b_reg[DATA_W-1:0];
    assign bi = b_reg[2*DATA_W-1:DATA_W];
    assign ur = u_reg[DATA_W-1:0];
    assign ui = u_reg[2*DATA_W-1:DATA_W];

    // Butterfly p/q addresses and twiddle index for the current stage.
    always_comb
    begin
        half_step = LOG_N'(1) << stage_reg;
        j_part    = cnt_reg & (half_step - LOG_N'(1));
        p_addr    = ((cnt_reg >> stage_reg) << (stage_reg + STAGE_W'(1))) | j_part;
        q_addr    = p_addr | half_step;
        ti_full   = j_part << (STAGE_W'(LOG_N - 1) - stage_reg);
        tw_idx    = ti_full[TW_W-1:0];
        for (int b = 0; b < LOG_N; b++)
            rev_cnt[b] = cnt_reg[LOG_N-1-b];
    end

    assign wc       = TW_TAB[{5'(tw_idx), 4'd0} +: COEF_W];
    assign ws       = TW_TAB[(MAX_N / 2) * COEF_W + {5'(tw_idx), 4'd0} +: COEF_W];
    assign win_coef = WIN_TAB[{kind_reg, root_reg, 6'(cnt_reg), 4'd0} +: COEF_W];

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LOAD_MUL:
            begin
                mul_a = DATA_W'(signed'(ring_rd_data));
                mul_b = {1'b0, win_coef};
            end
            ST_BF_M0: begin mul_a = br; mul_b = 17'(wc); end
            ST_BF_M1: begin mul_a = bi; mul_b = 17'(ws); end
            ST_BF_M2: begin mul_a = bi; mul_b = 17'(wc); end
            ST_BF_M3: begin mul_a = br; mul_b = 17'(ws); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign vr_sum  = acc_reg + 50'(prod_reg) + 50'sd16384;
    assign vi_sum  = acc_reg - 50'(prod_reg) + 50'sd16384;
    assign win_rnd = prod_reg + 49'sd8192;

    // Emission decision for an accepted sample.
    always_comb
    begin
        emit        = 1'b0;
        fill_next   = fill_reg;
        hop_cd_next = hop_cd_reg;
        wpos_next   = wpos_reg;
        if (accept)
        begin
            wpos_next = wpos_reg + LOG_N'(1);
            if (fill_reg != (LOG_N+1)'(FFT_LEN))
            begin
                fill_next = fill_reg + (LOG_N+1)'(1);
                if (fill_next == (LOG_N+1)'(FFT_LEN))
                begin
                    emit        = 1'b1;
                    hop_cd_next = hop_reg;
                end
            end
            else if (hop_cd_reg <= HOP_W'(1))
            begin
                emit        = 1'b1;
                hop_cd_next = hop_reg;
            end
            else
                hop_cd_next = hop_cd_reg - HOP_W'(1);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        stage_next   = stage_reg;
        m_valid_next = m_valid_reg;
        ring_wr_en   = 1'b0;
        ring_rd_en   = 1'b0;
        work_wr_en   = 1'b0;
        work_wr_addr = p_addr;
        work_wr_data = {sat32(36'(ui) + 36'(vi_reg)), sat32(36'(ur) + 36'(vr_reg))};
        work_rd_en   = 1'b0;
        work_rd_addr = q_addr;
        unique case (state_reg)
            ST_IDLE:
            begin
                ring_wr_en = accept;
                cnt_next   = '0;
                if (emit)
                    state_next = ST_LOAD_RD;
            end
            ST_LOAD_RD:
            begin
                ring_rd_en = 1'b1;
                state_next = ST_LOAD_MUL;
            end
            ST_LOAD_MUL:
                state_next = ST_LOAD_WR;
            ST_LOAD_WR:
            begin
                work_wr_en   = 1'b1;
                work_wr_addr = rev_cnt;
                work_wr_data = {{DATA_W{1'b0}}, win_rnd[DATA_W+13:14]};
                if (cnt_reg == LOG_N'(FFT_LEN - 1))
                begin
                    cnt_next   = '0;
                    stage_next = '0;
                    state_next = ST_BF_RDQ;
                end
                else
                begin
                    cnt_next   = cnt_reg + LOG_N'(1);
                    state_next = ST_LOAD_RD;
                end
            end
            ST_BF_RDQ:
            begin
                work_rd_en = 1'b1;
                state_next = ST_BF_RDP;
            end
            ST_BF_RDP:
            begin
                work_rd_en   = 1'b1;
                work_rd_addr = p_addr;
                state_next   = ST_BF_M0;
            end
            ST_BF_M0: state_next = ST_BF_M1;
            ST_BF_M1: state_next = ST_BF_M2;
            ST_BF_M2: state_next = ST_BF_M3;
            ST_BF_M3: state_next = ST_BF_VI;
            ST_BF_VI: state_next = ST_BF_WRP;
            ST_BF_WRP:
            begin
                work_wr_en = 1'b1;
                state_next = ST_BF_WRQ;
            end
            ST_BF_WRQ:
            begin
                work_wr_en   = 1'b1;
                work_wr_addr = q_addr;
                work_wr_data = {sat32(36'(ui) - 36'(vi_reg)), sat32(36'(ur) - 36'(vr_reg))};
                if (cnt_reg == LOG_N'(HALF_N - 1))
                begin
                    cnt_next = '0;
                    if (stage_reg == STAGE_W'(LOG_N - 1))
                        state_next = ST_OUT_RD;
                    else
                    begin
                        stage_next = stage_reg + STAGE_W'(1);
                        state_next = ST_BF_RDQ;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + LOG_N'(1);
                    state_next = ST_BF_RDQ;
                end
            end
            ST_OUT_RD:
            begin
                work_rd_en   = 1'b1;
                work_rd_addr = cnt_reg;
                state_next   = ST_OUT_CAP;
            end
            ST_OUT_CAP:
            begin
                m_valid_next = 1'b1;
                state_next   = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (m_tready)
                begin
                    m_valid_next = 1'b0;
                    if (cnt_reg == LOG_N'(HALF_N))
                        state_next = ST_IDLE;
                    else
                    begin
                        cnt_next   = cnt_reg + LOG_N'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            stage_reg   <= '0;
            wpos_reg    <= '0;
            fill_reg    <= '0;
            hop_cd_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            stage_reg   <= stage_next;
            wpos_reg    <= wpos_next;
            fill_reg    <= fill_next;
            hop_cd_reg  <= hop_cd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Configuration registers; a hop length of zero reads as one, above the frame saturates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_reg  <= HOP_W'(HOP_RESET);
            kind_reg <= 1'b0;
            root_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_HOP:
                begin
                    if (pwdata[HOP_W-1:0] == '0)
                        hop_reg <= HOP_W'(1);
                    else if (pwdata[HOP_W-1:0] > HOP_W'(FFT_LEN))
                        hop_reg <= HOP_W'(FFT_LEN);
                    else
                        hop_reg <= pwdata[HOP_W-1:0];
                end
                ADDR_KIND: kind_reg <= pwdata[0];
                ADDR_ROOT: root_reg <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_HOP:  prdata = 32'(hop_reg);
            ADDR_KIND: prdata = 32'(kind_reg);
            ADDR_ROOT: prdata = 32'(root_reg);
            default:   prdata = '0;
        endcase
    end

    // Datapath: shared multiplier, accumulator and output register.
    always_ff @(posedge clk)
    begin
        prod_reg <= 49'(mul_a) * 49'(mul_b);
        if (state_reg == ST_BF_RDP)
            b_reg <= work_rd_data;
        if (state_reg == ST_BF_M0)
            u_reg <= work_rd_data;
        if (state_reg == ST_BF_M1 || state_reg == ST_BF_M3)
            acc_reg <= 50'(prod_reg);
        if (state_reg == ST_BF_M2)
            vr_reg <= vr_sum[49:15];
        if (state_reg == ST_BF_VI)
            vi_reg <= vi_sum[49:15];
        if (state_reg == ST_OUT_CAP)
        begin
            m_data_reg <= {2'b00, work_rd_data, BIN_W'(cnt_reg)};
            m_last_reg <= (cnt_reg == LOG_N'(HALF_N));
        end
    end

    stft_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (FFT_LEN)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (wpos_reg),
        .wr_data (s_tdata),
        .rd_en   (ring_rd_en),
        .rd_addr (wpos_reg + cnt_reg),
        .rd_data (ring_rd_data)
    );

    stft_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (FFT_LEN)
    ) u_work (
        .clk     (clk),
        .wr_en   (work_wr_en),
        .wr_addr (work_wr_addr),
        .wr_data (work_wr_data),
        .rd_en   (work_rd_en),
        .rd_addr (work_rd_addr),
        .rd_data (work_rd_data)
    );

    // A bin waiting on the output means the frame is still running.
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !s_tready)
        else $error("input accepted while a bin is pending");

    a_last_is_top_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_last_reg) |-> (m_data_reg[BIN_W-1:0] == BIN_W'(HALF_N)))
        else $error("last flag on a bin other than the top one");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (LOG_N+1)'(FFT_LEN))
        else $error("fill count beyond frame size");

    a_frame_starts_load: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> (state_reg == ST_LOAD_RD && cnt_reg == '0))
        else $error("frame start did not enter windowing");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for stft_analysis_frames: drives PCM samples, writes the
// hop and window registers over APB, and checks every emitted bin against its own
// fixed-point STFT predictor. Depends on stft_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import stft_pkg::*;

    localparam int NFFT  = 64;
    localparam int NBINS = NFFT / 2 + 1;
    localparam longint ONE_Q30 = 64'sd1073741824;

    // One expected bin of a frame.
    typedef struct {
        logic [5:0]  idx;
        logic [31:0] re;
        logic [31:0] im;
        logic        last;
    } bin_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    stft_analysis_frames DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Samples waiting to be sent, and bins the predictor has produced so far.
    logic [15:0] sample_fifo[$];
    bin_t        bins_due[$];
    int          mismatches;
    bit          no_gaps;

    // Predictor copy of the block state and its registers.
    shortint     ring[NFFT];
    int          wr_pos;
    int          fill;
    int          countdown;
    int          hop;
    int          win_kind;
    int          win_root;
    int          win_tab[4][NFFT];
    int          tw_c[NFFT/2];
    int          tw_s[NFFT/2];

    // Round half up after an arithmetic shift; matches for both signs.
    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Q30 cosine and sine of num/den turns, Taylor series in the first quadrant.
    function automatic void turn_trig(input int num, input int den,
                                      output longint c_o, output longint s_o);
        bit [63:0] ph;
        bit [63:0] r;
        bit [63:0] a;
        bit [63:0] tc;
        bit [63:0] ts;
        longint    c;
        longint    s;
        ph = ((64'(num) & 64'hFF) << 32) / 64'(den);
        ph = ph & 64'hFFFF_FFFF;
        r  = ph & 64'h3FFF_FFFF;
        a  = (r * 64'd1686629713 + (64'd1 << 29)) >> 30;
        tc = 64'(ONE_Q30);
        ts = a;
        c  = ONE_Q30;
        s  = longint'(a);
        for (int n = 1; n <= 7; n++)
        begin
            tc = ((((tc * a) >> 30) * a) >> 30) / 64'((2 * n - 1) * (2 * n));
            ts = ((((ts * a) >> 30) * a) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                c = c - longint'(tc);
                s = s - longint'(ts);
            end
            else
            begin
                c = c + longint'(tc);
                s = s + longint'(ts);
            end
        end
        case (ph[31:30])
            2'd0:    begin c_o = c;  s_o = s;  end
            2'd1:    begin c_o = -s; s_o = c;  end
            2'd2:    begin c_o = -c; s_o = -s; end
            default: begin c_o = s;  s_o = -c; end
        endcase
    endfunction

    function automatic longint int_sqrt(longint v_in);
        bit [63:0] v;
        bit [63:0] r;
        bit [63:0] b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Fill the window and twiddle tables once, as the block's ROMs hold them.
    function automatic void build_tables();
        longint c;
        longint s;
        longint w;
        longint v;
        for (int i = 0; i < NFFT; i++)
        begin
            turn_trig(i, NFFT - 1, c, s);
            for (int k = 0; k < 2; k++)
            begin
                if (k == 0)
                    w = (ONE_Q30 - c) / 2;
                else
                    w = 64'sd579820585 - round_shift(64'sd493921239 * c, 30);
                w = clamp(w, 0, ONE_Q30);
                for (int rt = 0; rt < 2; rt++)
                begin
                    v = rt ? int_sqrt(w <<< 30) : w;
                    win_tab[k * 2 + rt][i] = int'(clamp(round_shift(v, 15), 0, 32767));
                end
            end
        end
        for (int i = 0; i < NFFT / 2; i++)
        begin
            turn_trig(i, NFFT, c, s);
            tw_c[i] = int'(clamp(round_shift(c, 15), -32768, 32767));
            tw_s[i] = int'(clamp(round_shift(s, 15), -32768, 32767));
        end
    endfunction

    // Windowed radix-2 DIT FFT of the ring, oldest sample first; queues bins 0..32.
    function automatic void predict_frame();
        int     xr[NFFT];
        int     xi[NFFT];
        int     t;
        int     j;
        int     p;
        int     q;
        int     ti;
        longint vr;
        longint vi;
        longint ur;
        longint ui;
        bin_t   b;
        for (int n = 0; n < NFFT; n++)
        begin
            xr[n] = int'(round_shift(longint'(ring[(wr_pos + n) % NFFT]) *
                                     longint'(win_tab[win_kind * 2 + win_root][n]), 14));
            xi[n] = 0;
        end
        for (int n = 0; n < NFFT; n++)
        begin
            j = 0;
            for (int bt = 0; bt < 6; bt++)
                if (n & (1 << bt))
                    j |= 1 << (5 - bt);
            if (n < j)
            begin
                t = xr[n]; xr[n] = xr[j]; xr[j] = t;
                t = xi[n]; xi[n] = xi[j]; xi[j] = t;
            end
        end
        for (int len = 2; len <= NFFT; len = len * 2)
        begin
            for (int base = 0; base < NFFT; base += len)
            begin
                for (int m = 0; m < len / 2; m++)
                begin
                    ti = (m * (NFFT / len)) & (NFFT / 2 - 1);
                    p  = base + m;
                    q  = base + m + len / 2;
                    vr = round_shift(longint'(xr[q]) * tw_c[ti] +
                                     longint'(xi[q]) * tw_s[ti], 15);
                    vi = round_shift(longint'(xi[q]) * tw_c[ti] -
                                     longint'(xr[q]) * tw_s[ti], 15);
                    ur = xr[p];
                    ui = xi[p];
                    xr[p] = int'(clamp(ur + vr, -64'sd2147483648, 64'sd2147483647));
                    xi[p] = int'(clamp(ui + vi, -64'sd2147483648, 64'sd2147483647));
                    xr[q] = int'(clamp(ur - vr, -64'sd2147483648, 64'sd2147483647));
                    xi[q] = int'(clamp(ui - vi, -64'sd2147483648, 64'sd2147483647));
                end
            end
        end
        for (int k = 0; k < NBINS; k++)
        begin
            b.idx  = 6'(k);
            b.re   = xr[k];
            b.im   = xi[k];
            b.last = (k == NFFT / 2);
            bins_due = {bins_due, b};
        end
    endfunction

    // Advance the ring and hop counters for one accepted sample.
    function automatic void take_sample(logic [15:0] smp);
        bit fire;
        fire = 0;
        ring[wr_pos] = shortint'(smp);
        wr_pos = (wr_pos + 1) % NFFT;
        if (fill < NFFT)
        begin
            fill++;
            if (fill == NFFT)
            begin
                fire = 1;
                countdown = hop;
            end
        end
        else if (countdown <= 1)
        begin
            fire = 1;
            countdown = hop;
        end
        else
            countdown--;
        if (fire)
            predict_frame();
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Sample driver: a new transaction is loaded only when the bus slot is free,
    // so tvalid gets one assignment per step and stays high across back-to-back items.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                take_sample(s_tdata);
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (sample_fifo.size() > 0)
            begin
                s_tdata  <= sample_fifo.pop_front();
                s_tvalid <= 1'b1;
                send_gap = no_gaps ? 0 : $urandom_range(0, 13);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Bin monitor: checks each transaction against the oldest expected bin, then
    // draws a fresh stall for the receiver.
    int recv_stall;
    always @(posedge clk or negedge rst_n)
    begin
        bin_t e;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (bins_due.size() == 0)
                    report("unexpected bin", 32'(m_tdata[5:0]), 32'd0);
                else
                begin
                    e = bins_due.pop_front();
                    if (m_tdata[5:0] !== e.idx)
                        report("bin_index", 32'(m_tdata[5:0]), 32'(e.idx));
                    if (m_tdata[37:6] !== e.re)
                        report("bin_real", m_tdata[37:6], e.re);
                    if (m_tdata[69:38] !== e.im)
                        report("bin_imag", m_tdata[69:38], e.im);
                    if (m_tlast !== e.last)
                        report("last_bin", 32'(m_tlast), 32'(e.last));
                end
                recv_stall = no_gaps ? 0 : $urandom_range(0, 13);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // APB write: setup cycle, then access cycle; the register takes the value at
    // the edge that ends the access cycle. The predictor follows the same rules.
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        int h;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_HOP)
        begin
            h   = value & 32'h7F;
            hop = (h < 1) ? 1 : ((h > NFFT) ? NFFT : h);
        end
        else if (addr == ADDR_KIND)
            win_kind = value & 1;
        else if (addr == ADDR_ROOT)
            win_root = value & 1;
        @(posedge clk);
    endtask

    // Let everything queued drain, then allow the block to settle back to idle.
    task automatic drain();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (sample_fifo.size() > 0 || s_tvalid || bins_due.size() > 0);
        repeat (30) @(posedge clk);
    endtask

    // Random sample content: mostly full range, sometimes quiet or clipped audio.
    function automatic logic [15:0] draw_sample(int style);
        case (style)
            0:       return 16'($urandom_range(0, 200)) - 16'd100;
            1:       return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int count);
        int style;
        style   = $urandom_range(0, 5);
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (count)
            sample_fifo = {sample_fifo, draw_sample(style)};
        drain();
    endtask

    initial
    begin
        logic [15:0] edge_vals[12];
        int          sent;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        mismatches = 0;
        no_gaps    = 1'b0;
        wr_pos     = 0;
        fill       = 0;
        countdown  = 0;
        hop        = HOP_RESET;
        win_kind   = 0;
        win_root   = 0;
        foreach (ring[i])
            ring[i] = 0;
        build_tables();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed start under the reset settings: full-scale values, zero, one LSB
        // either way and single set bits, then random fill up to the first frame.
        edge_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF,
                      16'h7FFF, 16'h8000, 16'h8000, 16'h5555, 16'hAAAA, 16'h4000};
        foreach (edge_vals[i])
            sample_fifo = {sample_fifo, edge_vals[i]};
        repeat (NFFT - 12)
            sample_fifo = {sample_fifo, draw_sample(2)};
        drain();
        // A full-scale square wave for one hop, which stays short of saturation in the FFT stages.
        for (int i = 0; i < HOP_RESET; i++)
            sample_fifo = {sample_fifo, ((i % 2) ? 16'h8000 : 16'h7FFF)};
        drain();
        sent = NFFT + HOP_RESET;

        // Register extremes: hop of zero reads as one, hop above the frame saturates,
        // and every window table gets used.
        reg_write(ADDR_HOP, 32'd0);
        reg_write(ADDR_KIND, 32'd1);
        run_phase(4);
        reg_write(ADDR_ROOT, 32'd1);
        run_phase(3);
        reg_write(ADDR_HOP, 32'd127);
        reg_write(ADDR_KIND, 32'd0);
        run_phase(70);
        reg_write(ADDR_HOP, 32'd64);
        reg_write(ADDR_ROOT, 32'd0);
        run_phase(64);
        // Hop shortened mid-countdown: the running count carries on from its old value.
        reg_write(ADDR_HOP, 32'd3);
        reg_write(ADDR_KIND, 32'd1);
        run_phase(10);
        sent += 151;

        while (sent < 380)
        begin
            reg_write(ADDR_HOP, ($urandom_range(0, 4) == 0) ? $urandom
                                                            : $urandom_range(2, 40));
            reg_write(ADDR_KIND, $urandom);
            reg_write(ADDR_ROOT, $urandom);
            sent += 20;
            run_phase(20);
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && bins_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
